>>> hw/rtl/rcbs_pkg.sv
// Package for the radial color blend shader: shared types and constants.
// Depends on nothing; used by the controller, the datapath and the top level.
`default_nettype none
package rcbs_pkg;

   // Operation codes carried in the request user bit.
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_SHADE = 1'b1;

   // Fraction 1.0 for the blend rate.
   localparam logic [15:0] RATE_ONE = 16'hFFFF;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_WALK,
      ST_DRAIN,
      ST_OUT
   } state_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic load_pixel;  // capture pixel and set color to white
      logic write_entry; // store the request as a table entry
      logic read_entry;  // present walk address to the table
      logic step;        // feed the fetched entry into the blend pipe
      logic show;        // copy color into the result register
   } cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic pipe_busy;   // blend pipe still holds entries
   } status_type;

endpackage
`default_nettype wire

>>> hw/rtl/rcbs_divider.sv
// Pipelined restoring divider giving floor(num * 65535 / den) as 16 bits.
// Uses no package; instantiated by the datapath.
`default_nettype none
module rcbs_divider #(
   parameter int DEN_BITS = 16
) (
   input  wire                 clock,
   input  wire                 in_valid,
   input  wire [DEN_BITS-1:0]  num,      // num <= den, den > 0
   input  wire [DEN_BITS-1:0]  den,
   input  wire [15:0]          in_tag,   // passed along
   output logic                out_valid,
   output logic [15:0]         quot,
   output logic [15:0]         out_tag,
   input  wire                 reset
);
   // Dividend num*65535 = (num<<16) - num; quotient fits 16 bits since num<=den.
   localparam int NB = DEN_BITS + 16;
   localparam int ST = 16;

   logic [NB-1:0]       rem_ff [1:ST];
   logic [DEN_BITS-1:0] den_ff [1:ST];
   logic [15:0]         q_ff   [1:ST];
   logic [15:0]         tag_ff [1:ST];
   logic [ST:1]         v_ff;

   // One quotient bit per stage, top bit first.
   for (genvar s = 0; s < ST; s++) begin : g_stage
      logic [NB-1:0]       rem_cur;
      logic [DEN_BITS-1:0] den_cur;
      logic [15:0]         q_cur;
      logic [15:0]         tag_cur;
      logic                v_cur;
      logic [NB-1:0]       trial;
      logic                fits;

      if (s == 0) begin : g_head
         // Stage zero forms the dividend.
         assign rem_cur = {num, 16'd0} - {16'd0, num};
         assign den_cur = den;
         assign q_cur   = 16'd0;
         assign tag_cur = in_tag;
         assign v_cur   = in_valid;
      end else begin : g_body
         assign rem_cur = rem_ff[s];
         assign den_cur = den_ff[s];
         assign q_cur   = q_ff[s];
         assign tag_cur = tag_ff[s];
         assign v_cur   = v_ff[s];
      end

      assign trial = {{16{1'b0}}, den_cur} << (15 - s);
      assign fits  = rem_cur >= trial;
      always_ff @(posedge clock) begin
         rem_ff[s+1] <= fits ? rem_cur - trial : rem_cur;
         den_ff[s+1] <= den_cur;
         q_ff[s+1]   <= {q_cur[14:0], fits};
         tag_ff[s+1] <= tag_cur;
         if (reset) begin
            v_ff[s+1] <= 1'b0;
         end else begin
            v_ff[s+1] <= v_cur;
         end
      end
   end

   assign out_valid = v_ff[ST];
   assign quot      = q_ff[ST];
   assign out_tag   = tag_ff[ST];
endmodule
`default_nettype wire

>>> hw/rtl/rcbs_datapath.sv
// Datapath: point table memory, distance stage, rate divider and blend stages.
// Depends on rcbs_pkg and rcbs_divider.
`default_nettype none
module rcbs_datapath #(
   parameter int NUM_POINTS = 128,
   parameter int COORD_BITS = 10,
   parameter int COLOR_BITS = 8,
   localparam int IDX_BITS = (NUM_POINTS > 1) ? $clog2(NUM_POINTS) : 1
) (
   input  wire                      clock,
   input  wire                      reset,
   input  rcbs_pkg::cmd_type        cmd,
   output rcbs_pkg::status_type     status,
   input  wire [IDX_BITS-1:0]       wr_addr,
   input  wire [IDX_BITS-1:0]       rd_addr,
   input  wire [COORD_BITS-1:0]     in_x,
   input  wire [COORD_BITS-1:0]     in_y,
   input  wire [7:0]                in_radius,
   input  wire [COLOR_BITS-1:0]     in_r,
   input  wire [COLOR_BITS-1:0]     in_g,
   input  wire [COLOR_BITS-1:0]     in_b,
   output logic [COORD_BITS-1:0]    out_x,
   output logic [COORD_BITS-1:0]    out_y,
   output logic [COLOR_BITS-1:0]    out_r,
   output logic [COLOR_BITS-1:0]    out_g,
   output logic [COLOR_BITS-1:0]    out_b
);
   localparam int EW  = 2 * COORD_BITS + 8 + 3 * COLOR_BITS;
   localparam int DB  = 2 * COORD_BITS + 1;
   localparam int DIV_DEP = 16;
   localparam int CNT_BITS = $clog2(DIV_DEP + 4);

   // Table memory; valid flops make entries read with radius zero after reset.
   logic [EW-1:0]          mem [NUM_POINTS];
   logic [NUM_POINTS-1:0]  valid_ff;
   logic [EW-1:0]          rd_data_ff;
   logic                   rd_valid_ff;
   logic                   fetch_ff;

   always_ff @(posedge clock) begin
      if (cmd.write_entry) begin
         mem[wr_addr] <= {in_x, in_y, in_radius, in_r, in_g, in_b};
      end
      rd_data_ff  <= mem[rd_addr];
      rd_valid_ff <= valid_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         fetch_ff <= 1'b0;
      end else begin
         if (cmd.write_entry) valid_ff[wr_addr] <= 1'b1;
         fetch_ff <= cmd.step;
      end
   end

   // Unpack the fetched entry; an unwritten entry has radius zero.
   logic [COORD_BITS-1:0] e_x, e_y;
   logic [7:0]            e_rad;
   logic [COLOR_BITS-1:0] e_r, e_g, e_b;
   always_comb begin
      {e_x, e_y, e_rad, e_r, e_g, e_b} = rd_data_ff;
      if (!rd_valid_ff) e_rad = 8'd0;
   end

   // Pixel and color registers.
   logic [COORD_BITS-1:0] px_ff, py_ff;
   logic [COLOR_BITS-1:0] cr_ff, cg_ff, cb_ff;

   // Distance stage: squared distance and squared radius.
   logic [COORD_BITS-1:0] dx, dy;
   assign dx = (px_ff >= e_x) ? px_ff - e_x : e_x - px_ff;
   assign dy = (py_ff >= e_y) ? py_ff - e_y : e_y - py_ff;

   logic [DB-1:0]  dd_ff;
   logic [15:0]    rr_ff;
   logic           d_v_ff;
   logic [3*COLOR_BITS-1:0] d_col_ff;
   always_ff @(posedge clock) begin
      dd_ff    <= DB'(dx) * DB'(dx) + DB'(dy) * DB'(dy);
      rr_ff    <= e_rad * e_rad;
      d_col_ff <= {e_r, e_g, e_b};
      if (reset) d_v_ff <= 1'b0;
      else       d_v_ff <= fetch_ff && (e_rad != 8'd0);
   end

   // Entries outside the radius drop out here.
   localparam int DW = (DB > 16) ? DB : 16;
   logic hit;
   assign hit = d_v_ff && (DW'(dd_ff) <= DW'(rr_ff));

   // The entry color rides beside the divider.
   logic            q_v;
   logic [15:0]     rate;
   logic [15:0]     q_tag;
   logic [3*COLOR_BITS-1:0] col_pipe [1:DIV_DEP];
   for (genvar s = 0; s < DIV_DEP; s++) begin : g_col
      if (s == 0) begin : g_head
         always_ff @(posedge clock) col_pipe[1] <= d_col_ff;
      end else begin : g_body
         always_ff @(posedge clock) col_pipe[s+1] <= col_pipe[s];
      end
   end

   rcbs_divider #(.DEN_BITS(DW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .in_valid (hit),
      .num      (DW'(dd_ff)),
      .den      (DW'(rr_ff)),
      .in_tag   (16'd0),
      .out_valid(q_v),
      .quot     (rate),
      .out_tag  (q_tag)
   );

   // Blend: products registered, then divide by 65535 with a correction.
   localparam int PB = COLOR_BITS + 17;
   logic [COLOR_BITS-1:0] pr, pg, pb;
   assign {pr, pg, pb} = col_pipe[DIV_DEP];

   function automatic logic [PB-1:0] mix(input logic [COLOR_BITS-1:0] c,
                                         input logic [COLOR_BITS-1:0] p,
                                         input logic [15:0] r);
      logic [PB-1:0] a;
      logic [PB-1:0] b;
      a = PB'(c) * PB'(r);
      b = PB'(p) * PB'(rcbs_pkg::RATE_ONE - r);
      return a + b + PB'(32767);
   endfunction

   // Sum s = t*65535 + rem; quotient = (s + (s>>16) + 1) >> 16 is exact here.
   function automatic logic [COLOR_BITS-1:0] div65535(input logic [PB-1:0] s);
      logic [PB:0] t;
      t = {1'b0, s} + (PB+1)'(s >> 16) + (PB+1)'(1);
      return COLOR_BITS'(t >> 16);
   endfunction

   // The blend depends on the running color, so hits are serialized by a
   // two-stage loop; the walk spaces its steps so hits never overlap in it.
   logic [PB-1:0] sr_ff, sg_ff, sb_ff;
   logic          m_v_ff;
   always_ff @(posedge clock) begin
      sr_ff <= mix(cr_ff, pr, rate);
      sg_ff <= mix(cg_ff, pg, rate);
      sb_ff <= mix(cb_ff, pb, rate);
      if (reset) m_v_ff <= 1'b0;
      else       m_v_ff <= q_v;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_pixel) begin
         px_ff <= in_x;
         py_ff <= in_y;
         cr_ff <= '1;
         cg_ff <= '1;
         cb_ff <= '1;
      end else if (m_v_ff) begin
         cr_ff <= div65535(sr_ff);
         cg_ff <= div65535(sg_ff);
         cb_ff <= div65535(sb_ff);
      end
      if (cmd.show) begin
         out_x <= px_ff;
         out_y <= py_ff;
         out_r <= cr_ff;
         out_g <= cg_ff;
         out_b <= cb_ff;
      end
   end

   // Count entries in flight from fetch to color update.
   logic [CNT_BITS-1:0] fl_ff;
   logic unused_tag;
   assign unused_tag = ^q_tag;
   always_ff @(posedge clock) begin
      if (reset) begin
         fl_ff <= '0;
      end else begin
         fl_ff <= fl_ff + CNT_BITS'(cmd.step) - CNT_BITS'(fetch_ff && !(e_rad != 8'd0))
                  - CNT_BITS'(d_v_ff && !hit) - CNT_BITS'(m_v_ff);
      end
   end
   assign status.pipe_busy = (fl_ff != '0) || unused_tag & 1'b0;
endmodule
`default_nettype wire

>>> hw/rtl/rcbs_ctrl.sv
// Controller: accepts items, walks the table with a read and a step phase per entry, drives output.
// Depends on rcbs_pkg.
`default_nettype none
module rcbs_ctrl #(
   parameter int NUM_POINTS = 128,
   localparam int IDX_BITS = (NUM_POINTS > 1) ? $clog2(NUM_POINTS) : 1,
   localparam int CNT_BITS = $clog2(NUM_POINTS + 1)
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_tvalid,
   output logic                  req_tready,
   input  wire                   req_op,
   input  wire [6:0]             req_index,
   input  wire [7:0]             active_points,
   output logic                  rsp_tvalid,
   input  wire                   rsp_tready,
   output rcbs_pkg::cmd_type     cmd,
   input  rcbs_pkg::status_type  status,
   output logic [IDX_BITS-1:0]   wr_addr,
   output logic [IDX_BITS-1:0]   rd_addr
);
   rcbs_pkg::state_type state_ff, state_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [CNT_BITS-1:0] limit_ff, limit_in;
   logic                ph_ff, ph_in;
   logic                rv_ff, rv_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rcbs_pkg::ST_IDLE;
         cnt_ff   <= '0;
         limit_ff <= '0;
         ph_ff    <= 1'b0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         limit_ff <= limit_in;
         ph_ff    <= ph_in;
         rv_ff    <= rv_in;
      end
   end

   assign wr_addr    = IDX_BITS'(req_index);
   assign rd_addr    = cnt_ff[IDX_BITS-1:0];
   assign rsp_tvalid = rv_ff;

   // Next state and commands.
   always_comb begin
      logic acc;
      acc = 1'b0;
      state_in = state_ff;
      cnt_in   = cnt_ff;
      limit_in = limit_ff;
      ph_in    = ph_ff;
      rv_in    = rv_ff && !rsp_tready;
      cmd      = '0;
      req_tready = 1'b0;
      case (state_ff)
         rcbs_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            acc = req_tvalid;
            if (acc && req_op == rcbs_pkg::OP_WRITE) begin
               cmd.write_entry = (32'(req_index) < NUM_POINTS);
            end else if (acc) begin
               cmd.load_pixel = 1'b1;
               cnt_in   = '0;
               ph_in    = 1'b0;
               limit_in = (32'(active_points) > NUM_POINTS) ? CNT_BITS'(NUM_POINTS)
                                                            : CNT_BITS'(active_points);
               state_in = rcbs_pkg::ST_WALK;
            end
         end
         rcbs_pkg::ST_WALK: begin
            // Read data is registered; step on the second phase.
            if (cnt_ff == limit_ff) begin
               state_in = rcbs_pkg::ST_DRAIN;
            end else begin
               ph_in = !ph_ff;
               cmd.step = ph_ff;
               if (ph_ff) cnt_in = cnt_ff + 1'b1;
            end
         end
         rcbs_pkg::ST_DRAIN: begin
            if (!status.pipe_busy && !cmd.step) state_in = rcbs_pkg::ST_OUT;
         end
         rcbs_pkg::ST_OUT: begin
            if (!rv_ff || rsp_tready) begin
               cmd.show = 1'b1;
               rv_in = 1'b1;
               state_in = rcbs_pkg::ST_IDLE;
            end
         end
         default: state_in = rcbs_pkg::ST_IDLE;
      endcase
   end
endmodule
`default_nettype wire

>>> hw/rtl/radial_color_blend_shader.sv
// Top level of the radial color blend shader: controller, datapath, config register.
// Depends on rcbs_pkg, rcbs_ctrl, rcbs_datapath and rcbs_divider.
//
//   channel | direction | tdata / data                           | tuser
//   req     | in        | idx, x, y, radius, r, g, b             | operation
//   rsp     | out       | x, y, r, g, b                          | -
//   csr     | in        | active_points                          | -
//
// A write item is stored and the block stays ready for the next item. A shade item
// walks the active entries with a read phase and a step phase each, then waits while
// the 16-stage divider and the blend pipe drain before its result is offered.
// Reset clears the table valid bits and sets the config register to 128.
// The result waits in an output register and the next item is taken meanwhile;
// a finished shade holds off further input until that register is free.
`default_nettype none
module radial_color_blend_shader #(
   parameter int NUM_POINTS = 128,
   parameter int COORD_BITS = 10,
   parameter int COLOR_BITS = 8
) (
   input  wire clock,
   input  wire reset,
   input  wire req_tvalid,
   output logic req_tready,
   // tdata: point_index, coord_x, coord_y, radius, red_in, green_in, blue_in
   input  wire [((7 + 2*COORD_BITS + 8 + 3*COLOR_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   // tuser: operation
   input  wire req_tuser,
   output logic rsp_tvalid,
   input  wire rsp_tready,
   // tdata: pixel_x, pixel_y, red_out, green_out, blue_out
   output logic [((2*COORD_BITS + 3*COLOR_BITS + 7) / 8) * 8 - 1:0] rsp_tdata,
   input  wire csr_wr_en,
   input  wire [7:0] csr_wr_data
);
   localparam int IDX_BITS = (NUM_POINTS > 1) ? $clog2(NUM_POINTS) : 1;
   localparam int OW = ((2*COORD_BITS + 3*COLOR_BITS + 7) / 8) * 8;

   logic [7:0] active_ff;
   always_ff @(posedge clock) begin
      if (reset) active_ff <= 8'd128;
      else if (csr_wr_en) active_ff <= csr_wr_data;
   end

   // Unpack request fields.
   logic [6:0]            f_idx;
   logic [COORD_BITS-1:0] f_x, f_y;
   logic [7:0]            f_rad;
   logic [COLOR_BITS-1:0] f_r, f_g, f_b;
   assign f_idx = req_tdata[6:0];
   assign f_x   = req_tdata[7 +: COORD_BITS];
   assign f_y   = req_tdata[7+COORD_BITS +: COORD_BITS];
   assign f_rad = req_tdata[7+2*COORD_BITS +: 8];
   assign f_r   = req_tdata[15+2*COORD_BITS +: COLOR_BITS];
   assign f_g   = req_tdata[15+2*COORD_BITS+COLOR_BITS +: COLOR_BITS];
   assign f_b   = req_tdata[15+2*COORD_BITS+2*COLOR_BITS +: COLOR_BITS];

   rcbs_pkg::cmd_type    cmd;
   rcbs_pkg::status_type status;
   logic [IDX_BITS-1:0]  wr_addr, rd_addr;
   logic [COORD_BITS-1:0] o_x, o_y;
   logic [COLOR_BITS-1:0] o_r, o_g, o_b;

   rcbs_ctrl #(.NUM_POINTS(NUM_POINTS)) u_ctrl (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_op(req_tuser), .req_index(f_idx), .active_points(active_ff),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .cmd(cmd), .status(status), .wr_addr(wr_addr), .rd_addr(rd_addr)
   );

   rcbs_datapath #(.NUM_POINTS(NUM_POINTS), .COORD_BITS(COORD_BITS),
                   .COLOR_BITS(COLOR_BITS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .wr_addr(wr_addr), .rd_addr(rd_addr),
      .in_x(f_x), .in_y(f_y), .in_radius(f_rad),
      .in_r(f_r), .in_g(f_g), .in_b(f_b),
      .out_x(o_x), .out_y(o_y), .out_r(o_r), .out_g(o_g), .out_b(o_b)
   );

   assign rsp_tdata = OW'({o_b, o_g, o_r, o_y, o_x});
endmodule
`default_nettype wire

>>> hw/rtl/rcbs_checker.sv
// Port-level checker for the radial color blend shader, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none
module rcbs_checker (
   input wire clock,
   input wire reset,
   input wire req_tvalid,
   input wire req_tready,
   input wire req_tuser,
   input wire rsp_tvalid,
   input wire rsp_tready
);
   // A result stays offered until taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid) else $error("rsp dropped");

   // Nothing is offered right after reset.
   a_rsp_reset: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_tvalid) else $error("rsp after reset");

   // A shade item blocks the input on the next cycle.
   a_shade_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser |=> !req_tready)
      else $error("ready during shade");

   // A write item produces no result the next cycle by itself.
   a_write_quiet: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !req_tuser && !rsp_tvalid |=> !rsp_tvalid)
      else $error("result from write");
endmodule

bind radial_color_blend_shader rcbs_checker u_rcbs_checker (
   .clock(clock), .reset(reset),
   .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tuser(req_tuser),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready)
);
`default_nettype wire

>>> tb/radial_color_blend_shader_tb.sv
// Testbench for the radial color blend shader: point writes, shading and the active count.
// Depends on rcbs_pkg and radial_color_blend_shader; predicts every pixel color itself.
`timescale 1ns / 100ps
`default_nettype none
module radial_color_blend_shader_tb;

   localparam int NPTS = 128;
   localparam int REQ_W = 64;
   localparam int RSP_W = 48;

   typedef struct {
      logic [9:0] x;
      logic [9:0] y;
      logic [7:0] radius;
      logic [7:0] col [3];
   } point_type;

   typedef struct {
      logic [9:0] px;
      logic [9:0] py;
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
   } pixel_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic req_tuser = rcbs_pkg::OP_WRITE;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic csr_wr_en = 1'b0;
   logic [7:0] csr_wr_data = '0;

   point_type point_copy [NPTS];
   int active_count;
   pixel_type pixel_queue [$];
   int errors = 0;
   int shades_sent = 0;
   int pixels_seen = 0;
   int burst_left = 0;

   radial_color_blend_shader dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Expected color of one pixel from the current point table.
   function automatic pixel_type shade_pixel(logic [9:0] px, logic [9:0] py);
      pixel_type res;
      longint unsigned c [3];
      longint unsigned dx, dy, dd, rr, rate;
      int cnt;
      cnt = (active_count > NPTS) ? NPTS : active_count;
      for (int k = 0; k < 3; k++) c[k] = 255;
      for (int i = 0; i < cnt; i++) begin
         if (point_copy[i].radius == 0) continue;
         dx = (px >= point_copy[i].x) ? px - point_copy[i].x : point_copy[i].x - px;
         dy = (py >= point_copy[i].y) ? py - point_copy[i].y : point_copy[i].y - py;
         dd = dx * dx + dy * dy;
         rr = point_copy[i].radius * point_copy[i].radius;
         if (dd > rr) continue;
         rate = (dd * 65535) / rr;
         for (int k = 0; k < 3; k++)
            c[k] = (c[k] * rate + point_copy[i].col[k] * (65535 - rate) + 32767) / 65535;
      end
      res.px = px;
      res.py = py;
      res.r = c[0][7:0];
      res.g = c[1][7:0];
      res.b = c[2][7:0];
      return res;
   endfunction

   // Sends one item in a burst/gap pattern and updates the prediction on acceptance.
   task automatic send_item(logic op, logic [6:0] idx, logic [9:0] x, logic [9:0] y,
                            logic [7:0] rad, logic [7:0] r, logic [7:0] g, logic [7:0] b);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {5'b0, b, g, r, rad, y, x, idx};
      do @(posedge clock); while (!req_tready);
      if (op == rcbs_pkg::OP_WRITE) begin
         point_copy[idx].x = x;
         point_copy[idx].y = y;
         point_copy[idx].radius = rad;
         point_copy[idx].col[0] = r;
         point_copy[idx].col[1] = g;
         point_copy[idx].col[2] = b;
      end else begin
         pixel_queue.push_back(shade_pixel(x, y));
         shades_sent++;
      end
   endtask

   task automatic idle_stream();
      req_tvalid <= 1'b0;
      burst_left = 0;
   endtask

   // Waits for all pixels, then for the block to settle, then writes the active count.
   task automatic set_active(int n);
      int guard;
      idle_stream();
      guard = 0;
      while (pixel_queue.size() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (300) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= n[7:0];
      @(posedge clock);
      csr_wr_en <= 1'b0;
      active_count = n;
   endtask

   task automatic rand_write(int max_idx, int max_rad);
      logic [6:0] idx;
      idx = 7'($urandom_range(0, max_idx));
      send_item(rcbs_pkg::OP_WRITE, idx, 10'($urandom_range(0, 1023)),
                10'($urandom_range(0, 1023)), 8'($urandom_range(0, max_rad)),
                8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   task automatic rand_shade_near(int max_idx);
      int i;
      int sx, sy;
      i = $urandom_range(0, max_idx);
      sx = int'(point_copy[i].x) + $urandom_range(0, 40) - 20;
      sy = int'(point_copy[i].y) + $urandom_range(0, 40) - 20;
      send_item(rcbs_pkg::OP_SHADE, 0, sx[9:0], sy[9:0], 0, 0, 0, 0);
   endtask

   // Empty table, extreme fields, zero radius, exact and outside radius.
   task automatic test_directed();
      send_item(rcbs_pkg::OP_SHADE, 7'h7F, 10'd0, 10'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      send_item(rcbs_pkg::OP_WRITE, 7'd0, 10'd100, 10'd100, 8'd0, 8'd0, 8'd0, 8'd0);
      send_item(rcbs_pkg::OP_SHADE, 0, 10'd100, 10'd100, 0, 0, 0, 0);
      send_item(rcbs_pkg::OP_WRITE, 7'd1, 10'd100, 10'd100, 8'd10, 8'd0, 8'd128, 8'd255);
      send_item(rcbs_pkg::OP_SHADE, 0, 10'd100, 10'd100, 0, 0, 0, 0);
      send_item(rcbs_pkg::OP_SHADE, 0, 10'd106, 10'd108, 0, 0, 0, 0);
      send_item(rcbs_pkg::OP_SHADE, 0, 10'd107, 10'd108, 0, 0, 0, 0);
      send_item(rcbs_pkg::OP_WRITE, 7'd127, 10'd1023, 10'd1023, 8'd255, 8'd255, 8'd0, 8'd0);
      send_item(rcbs_pkg::OP_SHADE, 0, 10'd1023, 10'd1023, 0, 0, 0, 0);
      send_item(rcbs_pkg::OP_SHADE, 0, 10'd900, 10'd1023, 0, 0, 0, 0);
      send_item(rcbs_pkg::OP_SHADE, 0, 10'd768, 10'd1023, 0, 0, 0, 0);
      send_item(rcbs_pkg::OP_WRITE, 7'd2, 10'd0, 10'd0, 8'd255, 8'h55, 8'hAA, 8'h0F);
      send_item(rcbs_pkg::OP_SHADE, 0, 10'd0, 10'd0, 0, 0, 0, 0);
      send_item(rcbs_pkg::OP_SHADE, 0, 10'd180, 10'd180, 0, 0, 0, 0);
      send_item(rcbs_pkg::OP_WRITE, 7'd3, 10'd3, 10'd4, 8'd5, 8'd200, 8'd10, 8'd60);
      send_item(rcbs_pkg::OP_SHADE, 0, 10'd0, 10'd0, 0, 0, 0, 0);
   endtask

   // Active count at its extremes and beyond the table size.
   task automatic test_active_count();
      int settings [5] = '{1, 0, 255, 2, 129};
      foreach (settings[s]) begin
         set_active(settings[s]);
         send_item(rcbs_pkg::OP_SHADE, 0, 10'd100, 10'd100, 0, 0, 0, 0);
         send_item(rcbs_pkg::OP_SHADE, 0, 10'd1023, 10'd1023, 0, 0, 0, 0);
         send_item(rcbs_pkg::OP_SHADE, 0, 10'd2, 10'd3, 0, 0, 0, 0);
      end
   endtask

   // Dense random scenes: writes and shades mostly aimed near existing points.
   task automatic test_random(int max_idx, int items);
      for (int n = 0; n < items; n++) begin
         case ($urandom_range(0, 9))
            0, 1, 2: rand_write(max_idx, 255);
            3: rand_write(127, 255);
            4: send_item(rcbs_pkg::OP_SHADE, 0, 10'($urandom), 10'($urandom), 0, 0, 0, 0);
            default: rand_shade_near(max_idx);
         endcase
      end
   endtask

   // Result checker with its own stall pattern.
   always @(posedge clock) begin
      pixel_type want;
      pixel_type got;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.px = rsp_tdata[9:0];
            got.py = rsp_tdata[19:10];
            got.r = rsp_tdata[27:20];
            got.g = rsp_tdata[35:28];
            got.b = rsp_tdata[43:36];
            pixels_seen++;
            if (pixel_queue.size() == 0) begin
               $error("unexpected pixel x=%0d y=%0d", got.px, got.py);
               errors++;
            end else begin
               want = pixel_queue.pop_front();
               if (got.px !== want.px) begin
                  $error("pixel_x expected %0d actual %0d", want.px, got.px); errors++;
               end
               if (got.py !== want.py) begin
                  $error("pixel_y expected %0d actual %0d", want.py, got.py); errors++;
               end
               if (got.r !== want.r) begin
                  $error("red_out expected %0d actual %0d", want.r, got.r); errors++;
               end
               if (got.g !== want.g) begin
                  $error("green_out expected %0d actual %0d", want.g, got.g); errors++;
               end
               if (got.b !== want.b) begin
                  $error("blue_out expected %0d actual %0d", want.b, got.b); errors++;
               end
            end
         end
         // Stalls come in phases: steady, light and heavy back-pressure.
         case ((pixels_seen / 40) % 3)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(0, 3) != 0);
            default: rsp_tready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   initial begin
      int guard;
      for (int i = 0; i < NPTS; i++) point_copy[i] = '{default: '0, col: '{0, 0, 0}};
      active_count = 128;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_active_count();
      set_active(8);
      test_random(7, 700);
      set_active(128);
      test_random(127, 600);
      set_active(1);
      test_random(3, 150);
      set_active(64);
      test_random(63, 350);
      idle_stream();
      guard = 0;
      while (pixel_queue.size() != 0 && guard < 500000) begin
         @(posedge clock);
         guard++;
      end
      repeat (300) @(posedge clock);
      $display("Shaded %0d pixels from directed cases and random scenes,", pixels_seen);
      $display("with the active count at zero, one, small, full and above the table size.");
      if (errors == 0 && pixel_queue.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #30ms;
      $display("DONE: errors detected");
      $finish;
   end
endmodule
`default_nettype wire

>>> filelist.f
hw/rtl/rcbs_pkg.sv
hw/rtl/rcbs_divider.sv
hw/rtl/rcbs_datapath.sv
hw/rtl/rcbs_ctrl.sv
hw/rtl/radial_color_blend_shader.sv
hw/rtl/rcbs_checker.sv
tb/radial_color_blend_shader_tb.sv
